@@ src/wsad_pkg.sv @@
package wsad_pkg;

   // fixed field widths
   localparam int AMP_W   = 16;
   localparam int FRAC_W  = 8;
   localparam int Q_W     = AMP_W + FRAC_W;
   localparam int SIGMA_W = 4;

   // defaults
   localparam int WINDOW_DEFAULT = 32;
   localparam logic [SIGMA_W-1:0] SIGMA_RESET = 4'd3;

   // shared add/subtract unit operations
   typedef enum logic [1:0] {
      ALU_ADD = 2'b01,
      ALU_SUB = 2'b10
   } alu_op_type;

   // one finished result
   typedef struct packed {
      logic           state_changed;
      logic           is_active;
      logic [Q_W-1:0] window_mean;
      logic [Q_W-1:0] window_deviation;
   } result_type;

endpackage

@@ src/wsad_ring.sv @@
module wsad_ring #(
   parameter int DEPTH  = 32,
   parameter int ADDR_W = 5
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [ADDR_W-1:0]           wr_addr,
   input  logic [wsad_pkg::AMP_W-1:0]  wr_data,
   input  logic                        rd_en,
   input  logic [ADDR_W-1:0]           rd_addr,
   output logic [wsad_pkg::AMP_W-1:0]  rd_data
);
   import wsad_pkg::*;

   logic [AMP_W-1:0] mem_ff [DEPTH];
   logic [AMP_W-1:0] rd_data_ff;

   // sample storage, one write and one registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/wsad_alu.sv @@
module wsad_alu #(
   parameter int WIDTH = 43
) (
   input  wsad_pkg::alu_op_type op,
   input  logic [WIDTH-1:0]     a,
   input  logic [WIDTH-1:0]     b,
   output logic [WIDTH-1:0]     res,
   output logic                 ge
);
   import wsad_pkg::*;

   logic [WIDTH:0] diff;
   logic [WIDTH:0] total;

   // one wide adder and one wide subtractor with borrow out
   assign diff  = {1'b0, a} - {1'b0, b};
   assign total = {1'b0, a} + {1'b0, b};
   assign ge    = ~diff[WIDTH];

   always_comb begin
      case (op)
         ALU_ADD: res = total[WIDTH-1:0];
         ALU_SUB: res = diff[WIDTH-1:0];
         default: res = a;
      endcase
   end

endmodule

@@ src/wsad_core.sv @@
module wsad_core #(
   parameter int WINDOW = wsad_pkg::WINDOW_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [wsad_pkg::AMP_W-1:0]    amp,
   input  logic [wsad_pkg::SIGMA_W-1:0]  sigma,
   input  logic                          out_busy,
   output logic                          idle,
   output logic                          done,
   output wsad_pkg::result_type          result
);
   import wsad_pkg::*;

   localparam int LOG_W  = $clog2(WINDOW);
   localparam int SLOT_W = LOG_W;
   localparam int N_W    = $clog2(WINDOW + 1);
   localparam int SUM_W  = AMP_W + LOG_W;
   localparam int SQ_W   = 2 * AMP_W + LOG_W;
   localparam int SP_W   = SQ_W + N_W;
   localparam int ROOT_W = (SP_W + 2 * FRAC_W + 1) / 2;
   localparam int X_W    = 2 * ROOT_W;
   localparam int REM_W  = ROOT_W + 2;
   localparam int MNUM_W = SUM_W + FRAC_W;
   localparam int NUM_W  = (ROOT_W > MNUM_W) ? ROOT_W : MNUM_W;
   localparam int AW     = (SP_W > REM_W) ? SP_W : REM_W;
   localparam int CNT_W  = $clog2(NUM_W + 1);
   localparam int THR_W  = Q_W + SIGMA_W + 1;

   typedef enum logic [10:0] {
      ST_IDLE    = 11'b000_0000_0001,
      ST_SQNEW   = 11'b000_0000_0010,
      ST_SQOLD   = 11'b000_0000_0100,
      ST_SUMS    = 11'b000_0000_1000,
      ST_SUMSQ   = 11'b000_0001_0000,
      ST_NMUL    = 11'b000_0010_0000,
      ST_SPREAD  = 11'b000_0100_0000,
      ST_ROOT    = 11'b000_1000_0000,
      ST_DIVDEV  = 11'b001_0000_0000,
      ST_DIVMEAN = 11'b010_0000_0000,
      ST_DONE    = 11'b100_0000_0000
   } state_type;

   state_type         state_ff, state_in;
   logic [AMP_W-1:0]  amp_ff, amp_in;
   logic [AMP_W-1:0]  old_ff, old_in;
   logic [2*SUM_W-1:0] sq_ff, sq_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [N_W-1:0]    fill_ff, fill_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [SQ_W-1:0]   sumsq_ff, sumsq_in;
   logic [SP_W-1:0]   acc_ff, acc_in;
   logic [X_W-1:0]    x_ff, x_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic [NUM_W-1:0]  num_ff, num_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [Q_W-1:0]    mean_ff, mean_in;
   logic [Q_W-1:0]    dev_ff, dev_in;
   logic              active_ff, active_in;
   logic [Q_W-1:0]    prev_mean_ff, prev_mean_in;
   logic [Q_W-1:0]    prev_dev_ff, prev_dev_in;
   logic [Q_W-1:0]    release_ff, release_in;

   // shared unit and multiplier hookup
   alu_op_type         alu_op;
   logic [AW-1:0]      alu_a;
   logic [AW-1:0]      alu_b;
   logic [AW-1:0]      alu_res;
   logic               alu_ge;
   logic [SUM_W-1:0]   mul_a;
   logic [2*SUM_W-1:0] prod;
   logic [AMP_W-1:0]   ring_rd;

   logic                    full;
   logic [REM_W-1:0]        root_sh;
   logic [REM_W-1:0]        div_sh;
   logic [NUM_W-1:0]        quot_next;
   logic [Q_W+SIGMA_W-1:0]  sig_prod;
   logic [THR_W-1:0]        thresh;
   logic [THR_W-1:0]        amp_x;
   logic [Q_W-1:0]          amp_q;

   wsad_alu #(
      .WIDTH (AW)
   ) u_alu (
      .op  (alu_op),
      .a   (alu_a),
      .b   (alu_b),
      .res (alu_res),
      .ge  (alu_ge)
   );

   wsad_ring #(
      .DEPTH  (WINDOW),
      .ADDR_W (SLOT_W)
   ) u_ring (
      .clock   (clock),
      .wr_en   (state_ff == ST_SQNEW),
      .wr_addr (slot_ff),
      .wr_data (amp_ff),
      .rd_en   (start),
      .rd_addr (slot_ff),
      .rd_data (ring_rd)
   );

   // squares of samples and of the running sum
   assign prod = mul_a * mul_a;

   always_comb begin
      case (state_ff)
         ST_SQNEW: mul_a = SUM_W'(amp_ff);
         ST_SQOLD: mul_a = SUM_W'(old_ff);
         default:  mul_a = sum_ff;
      endcase
   end

   assign full = (fill_ff == N_W'(WINDOW));

   // shifted remainders for the square root and divide steps
   assign root_sh   = {rem_ff[REM_W-3:0], x_ff[X_W-1 -: 2]};
   assign div_sh    = {rem_ff[REM_W-2:0], num_ff[NUM_W-1]};
   assign quot_next = {num_ff[NUM_W-2:0], alu_ge};

   // start threshold from the previous mean and deviation
   assign sig_prod = sigma * prev_dev_ff;
   assign thresh   = THR_W'(prev_mean_ff) + THR_W'(sig_prod);
   assign amp_q    = {amp_ff, {FRAC_W{1'b0}}};
   assign amp_x    = THR_W'(amp_q);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      amp_in       = amp_ff;
      old_in       = old_ff;
      sq_in        = sq_ff;
      slot_in      = slot_ff;
      fill_in      = fill_ff;
      sum_in       = sum_ff;
      sumsq_in     = sumsq_ff;
      acc_in       = acc_ff;
      x_in         = x_ff;
      rem_in       = rem_ff;
      root_in      = root_ff;
      num_in       = num_ff;
      cnt_in       = cnt_ff;
      mean_in      = mean_ff;
      dev_in       = dev_ff;
      active_in    = active_ff;
      prev_mean_in = prev_mean_ff;
      prev_dev_in  = prev_dev_ff;
      release_in   = release_ff;
      alu_op       = ALU_ADD;
      alu_a        = '0;
      alu_b        = '0;
      done         = 1'b0;
      result.state_changed    = 1'b0;
      result.is_active        = active_ff;
      result.window_mean      = mean_ff;
      result.window_deviation = dev_ff;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               amp_in   = amp;
               state_in = ST_SQNEW;
            end
         end

         // new sample square, capture the sample that leaves the window
         ST_SQNEW: begin
            sq_in    = prod;
            old_in   = full ? ring_rd : '0;
            state_in = ST_SQOLD;
         end

         ST_SQOLD: begin
            sumsq_in = sumsq_ff + sq_ff[SQ_W-1:0];
            sum_in   = sum_ff + SUM_W'(amp_ff);
            sq_in    = prod;
            state_in = ST_SUMS;
         end

         ST_SUMS: begin
            sumsq_in = sumsq_ff - sq_ff[SQ_W-1:0];
            sum_in   = sum_ff - SUM_W'(old_ff);
            if (!full) begin
               fill_in = fill_ff + 1'b1;
            end
            if (slot_ff == SLOT_W'(WINDOW - 1)) begin
               slot_in = '0;
            end else begin
               slot_in = slot_ff + 1'b1;
            end
            state_in = ST_SUMSQ;
         end

         // n goes to the top of the shifter so its msb is consumed first
         ST_SUMSQ: begin
            sq_in    = prod;
            acc_in   = '0;
            num_in   = {fill_ff, {(NUM_W - N_W){1'b0}}};
            cnt_in   = CNT_W'(N_W - 1);
            state_in = ST_NMUL;
         end

         // n times square sum, shift and add from the top bit of n
         ST_NMUL: begin
            alu_op = ALU_ADD;
            alu_a  = AW'({acc_ff[SP_W-2:0], 1'b0});
            alu_b  = num_ff[NUM_W-1] ? AW'(sumsq_ff) : '0;
            acc_in = alu_res[SP_W-1:0];
            num_in = {num_ff[NUM_W-2:0], 1'b0};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_SPREAD;
            end
         end

         // n times square sum minus sum squared gives the spread, scaled for the root
         ST_SPREAD: begin
            alu_op   = ALU_SUB;
            alu_a    = AW'(acc_ff);
            alu_b    = AW'(sq_ff);
            x_in     = X_W'({alu_res[SP_W-1:0], {(2*FRAC_W){1'b0}}});
            rem_in   = '0;
            root_in  = '0;
            cnt_in   = CNT_W'(ROOT_W - 1);
            state_in = ST_ROOT;
         end

         // square root, one result bit a cycle
         ST_ROOT: begin
            alu_op = ALU_SUB;
            alu_a  = AW'(root_sh);
            alu_b  = AW'({root_ff, 2'b01});
            if (alu_ge) begin
               rem_in  = alu_res[REM_W-1:0];
               root_in = {root_ff[ROOT_W-2:0], 1'b1};
            end else begin
               rem_in  = root_sh;
               root_in = {root_ff[ROOT_W-2:0], 1'b0};
            end
            x_in   = {x_ff[X_W-3:0], 2'b00};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               num_in   = NUM_W'(root_in);
               rem_in   = '0;
               cnt_in   = CNT_W'(NUM_W - 1);
               state_in = ST_DIVDEV;
            end
         end

         // restoring divide by n, deviation then mean
         ST_DIVDEV, ST_DIVMEAN: begin
            alu_op = ALU_SUB;
            alu_a  = AW'(div_sh);
            alu_b  = AW'(fill_ff);
            rem_in = alu_ge ? alu_res[REM_W-1:0] : div_sh;
            num_in = quot_next;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               if (state_ff == ST_DIVDEV) begin
                  dev_in   = quot_next[Q_W-1:0];
                  num_in   = NUM_W'({sum_ff, {FRAC_W{1'b0}}});
                  rem_in   = '0;
                  cnt_in   = CNT_W'(NUM_W - 1);
                  state_in = ST_DIVMEAN;
               end else begin
                  mean_in  = quot_next[Q_W-1:0];
                  state_in = ST_DONE;
               end
            end
         end

         // activity decision against the previous values
         ST_DONE: begin
            if (!out_busy) begin
               if (!active_ff) begin
                  if (full && (amp_x > thresh)) begin
                     active_in            = 1'b1;
                     release_in           = prev_mean_ff;
                     result.state_changed = 1'b1;
                  end
               end else if (amp_q < release_ff) begin
                  active_in            = 1'b0;
                  result.state_changed = 1'b1;
               end
               result.is_active = active_in;
               prev_mean_in     = mean_ff;
               prev_dev_in      = dev_ff;
               done             = 1'b1;
               state_in         = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign idle = (state_ff == ST_IDLE);

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         slot_ff      <= '0;
         fill_ff      <= '0;
         sum_ff       <= '0;
         sumsq_ff     <= '0;
         active_ff    <= 1'b0;
         prev_mean_ff <= '0;
         prev_dev_ff  <= '0;
         release_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         slot_ff      <= slot_in;
         fill_ff      <= fill_in;
         sum_ff       <= sum_in;
         sumsq_ff     <= sumsq_in;
         active_ff    <= active_in;
         prev_mean_ff <= prev_mean_in;
         prev_dev_ff  <= prev_dev_in;
         release_ff   <= release_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      amp_ff  <= amp_in;
      old_ff  <= old_in;
      sq_ff   <= sq_in;
      acc_ff  <= acc_in;
      x_ff    <= x_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      num_ff  <= num_in;
      cnt_ff  <= cnt_in;
      mean_ff <= mean_in;
      dev_ff  <= dev_in;
   end

endmodule

@@ src/windowed_sigma_activity_detector.sv @@
// a new transaction is taken only once the core is idle, after the last result has gone into
//   the output register; the shared add/subtract unit runs the n multiply, the square root
//   and two divides one bit per cycle
// reset: synchronous, active high; clears sums, fill count, activity state, sigma factor to 3
module windowed_sigma_activity_detector #(
   parameter int WINDOW = wsad_pkg::WINDOW_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [wsad_pkg::AMP_W-1:0]    req_amplitude,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_state_changed,
   output logic                          rsp_is_active,
   output logic [wsad_pkg::Q_W-1:0]      rsp_window_mean,
   output logic [wsad_pkg::Q_W-1:0]      rsp_window_deviation,
   input  logic                          csr_wr_en,
   input  logic [wsad_pkg::SIGMA_W-1:0]  csr_wr_data
);
   import wsad_pkg::*;

   logic [SIGMA_W-1:0] sigma_ff, sigma_in;
   logic               rsp_valid_ff, rsp_valid_in;
   result_type         rsp_data_ff;
   logic               core_idle;
   logic               core_done;
   logic               out_busy;
   logic               req_accept;
   result_type         core_result;

   assign req_stall  = ~core_idle;
   assign req_accept = req_valid & ~req_stall;
   assign out_busy   = rsp_valid_ff & rsp_stall;

   wsad_core #(
      .WINDOW (WINDOW)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .start    (req_accept),
      .amp      (req_amplitude),
      .sigma    (sigma_ff),
      .out_busy (out_busy),
      .idle     (core_idle),
      .done     (core_done),
      .result   (core_result)
   );

   // sigma factor register
   assign sigma_in = csr_wr_en ? csr_wr_data : sigma_ff;

   // output register valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (core_done) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sigma_ff     <= SIGMA_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         sigma_ff     <= sigma_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // output payload
   always_ff @(posedge clock) begin
      if (core_done) begin
         rsp_data_ff <= core_result;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_state_changed    = rsp_data_ff.state_changed;
   assign rsp_is_active        = rsp_data_ff.is_active;
   assign rsp_window_mean      = rsp_data_ff.window_mean;
   assign rsp_window_deviation = rsp_data_ff.window_deviation;

   // an accepted transaction keeps the block busy in the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> req_stall)
      else $error("block ready right after accepting a transaction");

   // a result is handed over only when the output register can take it
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      core_done |-> !(rsp_valid_ff && rsp_stall))
      else $error("result written over a stalled transaction");

   // output valid rises only from a finished computation
   a_valid_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(core_done))
      else $error("output valid raised without a finished result");

endmodule

@@ test/sigma_window_checker.sv @@
module sigma_window_checker #(
   parameter int WINDOW = wsad_pkg::WINDOW_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_stall,
   input  logic [wsad_pkg::AMP_W-1:0]   req_amplitude,
   input  logic                         rsp_valid,
   input  logic                         rsp_stall,
   input  logic                         rsp_state_changed,
   input  logic                         rsp_is_active,
   input  logic [wsad_pkg::Q_W-1:0]     rsp_window_mean,
   input  logic [wsad_pkg::Q_W-1:0]     rsp_window_deviation,
   input  logic                         csr_wr_en,
   input  logic [wsad_pkg::SIGMA_W-1:0] csr_wr_data,
   output int                           error_count,
   output int                           pending_count,
   output int                           checked_count,
   output int                           change_count
);
   import wsad_pkg::*;

   // shadow copy of the detector state
   logic [AMP_W-1:0]   sample_history [WINDOW];
   int unsigned        history_slot;
   int unsigned        history_fill;
   logic [63:0]        amp_sum;
   logic [63:0]        amp_square_sum;
   logic               activity;
   logic [Q_W-1:0]     last_mean;
   logic [Q_W-1:0]     last_deviation;
   logic [Q_W-1:0]     release_level;
   logic [SIGMA_W-1:0] sigma_factor;

   // expected results, oldest first
   result_type expected_results [$];
   result_type oldest;

   // slide the window by one sample and queue the result it yields
   function automatic void advance_window(input logic [AMP_W-1:0] amp);
      logic [63:0] amp_q;
      logic [63:0] dropped;
      logic [63:0] count;
      logic [63:0] mean;
      logic [63:0] spread;
      logic [63:0] variance;
      logic [63:0] root;
      logic [63:0] trial;
      logic [63:0] threshold;
      result_type  predicted;

      amp_q = {40'd0, amp, 8'd0};

      // full window: the oldest sample leaves the sums
      if (history_fill >= WINDOW) begin
         dropped = {48'd0, sample_history[history_slot]};
         amp_sum -= dropped;
         amp_square_sum -= dropped * dropped;
      end else begin
         history_fill++;
      end
      sample_history[history_slot] = amp;
      amp_sum += {48'd0, amp};
      amp_square_sum += {48'd0, amp} * {48'd0, amp};
      history_slot = (history_slot + 1) % WINDOW;

      // mean in q16.8, population variance scaled by 2^16 so that its root is q16.8
      count    = 64'(history_fill);
      mean     = (amp_sum << 8) / count;
      spread   = count * amp_square_sum - amp_sum * amp_sum;
      variance = (spread << 16) / (count * count);

      // floor square root, one result bit at a time from the top
      root = '0;
      for (int b = 31; b >= 0; b--) begin
         trial = root | (64'd1 << b);
         if (trial * trial <= variance) root = trial;
      end

      // activity decision against the previous sample's statistics
      predicted.state_changed = 1'b0;
      if (!activity) begin
         threshold = 64'(last_mean) + 64'(sigma_factor) * 64'(last_deviation);
         if (history_fill == WINDOW && amp_q > threshold) begin
            activity = 1'b1;
            predicted.state_changed = 1'b1;
            release_level = last_mean;
         end
      end else if (amp_q < 64'(release_level)) begin
         activity = 1'b0;
         predicted.state_changed = 1'b1;
      end

      last_mean      = mean[Q_W-1:0];
      last_deviation = root[Q_W-1:0];

      predicted.is_active        = activity;
      predicted.window_mean      = last_mean;
      predicted.window_deviation = last_deviation;
      expected_results.push_back(predicted);
      if (predicted.state_changed) change_count++;
   endfunction

   // watch both channels and the register port at each rising edge
   always @(posedge clock) begin
      if (reset) begin
         history_slot   = 0;
         history_fill   = 0;
         amp_sum        = '0;
         amp_square_sum = '0;
         activity       = 1'b0;
         last_mean      = '0;
         last_deviation = '0;
         release_level  = '0;
         sigma_factor   = SIGMA_RESET;
         error_count    = 0;
         checked_count  = 0;
         change_count   = 0;
         expected_results.delete();
      end else begin
         if (csr_wr_en) sigma_factor = csr_wr_data;

         // result transaction against the oldest expectation
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               $error("result with no sample pending: mean %0d deviation %0d",
                      rsp_window_mean, rsp_window_deviation);
               error_count++;
            end else begin
               oldest = expected_results.pop_front();
               checked_count++;
               if (rsp_state_changed !== oldest.state_changed) begin
                  $error("state_changed: expected %0b, actual %0b",
                         oldest.state_changed, rsp_state_changed);
                  error_count++;
               end
               if (rsp_is_active !== oldest.is_active) begin
                  $error("is_active: expected %0b, actual %0b",
                         oldest.is_active, rsp_is_active);
                  error_count++;
               end
               if (rsp_window_mean !== oldest.window_mean) begin
                  $error("window_mean: expected %0d, actual %0d",
                         oldest.window_mean, rsp_window_mean);
                  error_count++;
               end
               if (rsp_window_deviation !== oldest.window_deviation) begin
                  $error("window_deviation: expected %0d, actual %0d",
                         oldest.window_deviation, rsp_window_deviation);
                  error_count++;
               end
            end
         end

         // sample transaction feeds the shadow window
         if (req_valid && !req_stall) advance_window(req_amplitude);
      end
      pending_count = expected_results.size();
   end

endmodule

@@ test/windowed_sigma_activity_detector_test.sv @@
module windowed_sigma_activity_detector_test;
   import wsad_pkg::*;

   localparam int SETTLE_CYCLES = 110;
   localparam int PHASE_COUNT   = 8;
   localparam int PHASE_ITEMS   = 120;
   localparam int LONG_HOLD     = 1500;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [AMP_W-1:0]   req_amplitude;
   logic               rsp_valid;
   logic               rsp_stall;
   logic               rsp_state_changed;
   logic               rsp_is_active;
   logic [Q_W-1:0]     rsp_window_mean;
   logic [Q_W-1:0]     rsp_window_deviation;
   logic               csr_wr_en;
   logic [SIGMA_W-1:0] csr_wr_data;

   int error_count;
   int pending_count;
   int checked_count;
   int change_count;
   int samples_sent;
   int sigma_writes;
   int hold_request;
   bit steady;

   // extremes, alternating swings and a spike while the window is still filling
   logic [AMP_W-1:0] corner_amps [$] = '{
      16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0001, 16'hFFFE, 16'h5555,
      16'hAAAA, 16'h8000, 16'h7FFF, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF
   };

   windowed_sigma_activity_detector u_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_amplitude        (req_amplitude),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_state_changed    (rsp_state_changed),
      .rsp_is_active        (rsp_is_active),
      .rsp_window_mean      (rsp_window_mean),
      .rsp_window_deviation (rsp_window_deviation),
      .csr_wr_en            (csr_wr_en),
      .csr_wr_data          (csr_wr_data)
   );

   sigma_window_checker u_checker (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_amplitude        (req_amplitude),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_state_changed    (rsp_state_changed),
      .rsp_is_active        (rsp_is_active),
      .rsp_window_mean      (rsp_window_mean),
      .rsp_window_deviation (rsp_window_deviation),
      .csr_wr_en            (csr_wr_en),
      .csr_wr_data          (csr_wr_data),
      .error_count          (error_count),
      .pending_count        (pending_count),
      .checked_count        (checked_count),
      .change_count         (change_count)
   );

   // clock
   initial clock = 1'b0;
   always #5 clock = ~clock;

   // sender gap: mostly none or short, a few long
   function automatic int pick_gap();
      int r;
      if (steady) return 0;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 8);
      if (r < 97) return $urandom_range(9, 120);
      return $urandom_range(121, 400);
   endfunction

   function automatic logic [AMP_W-1:0] clamp_amp(input int level);
      if (level < 0) return '0;
      if (level > 65535) return '1;
      return level[AMP_W-1:0];
   endfunction

   // one sample transaction, then an optional idle gap
   task automatic send_sample(input logic [AMP_W-1:0] amp);
      int gap;
      req_amplitude = amp;
      req_valid = 1'b1;
      do @(posedge clock); while (req_stall);
      samples_sent++;
      @(negedge clock);
      gap = pick_gap();
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   // stop offering and let every pending result come out
   task automatic wait_for_results();
      req_valid = 1'b0;
      while (pending_count != 0) @(negedge clock);
   endtask

   task automatic write_sigma(input logic [SIGMA_W-1:0] value);
      wait_for_results();
      csr_wr_data = value;
      csr_wr_en = 1'b1;
      @(negedge clock);
      csr_wr_en = 1'b0;
      sigma_writes++;
   endtask

   // quiet baseline filling the window, a burst above it, then a fall back
   task automatic run_episode();
      int base;
      int spread;
      int level;
      base = $urandom_range(0, 60000);
      case ($urandom_range(0, 2))
         0: spread = 0;
         1: spread = $urandom_range(1, 8);
         default: spread = $urandom_range(9, 600);
      endcase
      repeat ($urandom_range(WINDOW_DEFAULT, WINDOW_DEFAULT + 8)) begin
         send_sample(clamp_amp(base + int'($urandom_range(0, 2 * spread)) - spread));
      end

      // a flat baseline makes the equal-to-threshold case reachable
      repeat ($urandom_range(1, 5)) begin
         case ($urandom_range(0, 3))
            0: level = base;
            1: level = base + 1;
            default: level = int'($urandom_range(base, 65535));
         endcase
         send_sample(clamp_amp(level));
      end

      // equal to and just under the release limit
      repeat ($urandom_range(1, 4)) begin
         case ($urandom_range(0, 2))
            0: level = base;
            1: level = base - 1;
            default: level = int'($urandom_range(0, base));
         endcase
         send_sample(clamp_amp(level));
      end
   endtask

   // unshaped samples and extremes
   task automatic run_noise();
      repeat ($urandom_range(1, 6)) begin
         case ($urandom_range(0, 3))
            0: send_sample(16'h0000);
            1: send_sample(16'hFFFF);
            default: send_sample(AMP_W'($urandom_range(0, 65535)));
         endcase
      end
   endtask

   // result side: random stalls, a long hold on request
   initial begin
      int r;
      int stall_left;
      stall_left = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request > 0) begin
            stall_left = hold_request;
            hold_request = 0;
         end else if (stall_left == 0 && !steady) begin
            r = $urandom_range(0, 999);
            if (r >= 995) stall_left = $urandom_range(20, 150);
            else if (r >= 850) stall_left = $urandom_range(1, 3);
         end
         rsp_stall = (stall_left > 0);
         if (stall_left > 0) stall_left--;
      end
   end

   // stimulus and verdict
   initial begin
      int phase;
      int phase_start;
      reset = 1'b1;
      req_valid = 1'b0;
      req_amplitude = '0;
      csr_wr_en = 1'b0;
      csr_wr_data = SIGMA_RESET;
      hold_request = 0;
      steady = 1'b0;
      samples_sent = 0;
      sigma_writes = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed corners at the reset sigma factor
      foreach (corner_amps[i]) send_sample(corner_amps[i]);

      // sigma settings: maximum, one, zero, back to reset value, then random
      for (phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            0: write_sigma(4'd15);
            1: write_sigma(4'd1);
            2: write_sigma(4'd0);
            3: write_sigma(SIGMA_RESET);
            default: write_sigma(SIGMA_W'($urandom_range(1, 15)));
         endcase
         steady = (phase == 4);
         if (phase == 5) hold_request = LONG_HOLD;
         phase_start = samples_sent;
         while (samples_sent - phase_start < PHASE_ITEMS) begin
            if ($urandom_range(0, 4) == 0) run_noise();
            else run_episode();
            // sender pauses until the block has emptied
            if (phase == 6) wait_for_results();
         end
      end

      wait_for_results();
      repeat (SETTLE_CYCLES) @(negedge clock);
      $display("covered %0d samples across %0d sigma settings, with a long output hold",
               samples_sent, sigma_writes + 1);
      $display("checked %0d results, %0d activity state changes",
               checked_count, change_count);
      if (error_count == 0 && pending_count == 0) begin
         $display("windowed_sigma_activity_detector: match");
      end else begin
         $display("windowed_sigma_activity_detector: mismatch");
      end
      $finish;
   end

   // run limit
   initial begin
      #30_000_000;
      $display("windowed_sigma_activity_detector: mismatch");
      $finish;
   end

endmodule
